FILE: hdl/sadq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue package
//
// Shared constants, operation and result codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sadq_pkg;

    // Default number of alarm slots.
    localparam int NUM_ALARMS_DEFAULT = 16;

    // Reset value of the tick period register, periodic tick and compare value.
    localparam logic [31:0] TICK_PERIOD_RESET = 32'd200000;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_TICK_PERIOD = 1'b0;

    // Operation codes of an input item.
    localparam logic [1:0] FUNC_REBASE = 2'd0;
    localparam logic [1:0] FUNC_SLEEP  = 2'd1;
    localparam logic [1:0] FUNC_INTR   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_WOKEN   = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;
    localparam logic [1:0] KIND_DUP     = 2'd3;

    // Source of the alarm id carried by a result.
    typedef enum logic [1:0] {
        ID_ITEM,
        ID_HEAD,
        ID_ZERO
    } id_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_item;
        logic       rd_en;
        logic       rd_walk;
        logic       wr_now;
        logic       wr_sleep;
        logic       add_sleep;
        logic       walk_clr;
        logic       walk_inc;
        logic       insert;
        logic       tick_adv;
        logic       cmp_int;
        logic       emit;
        logic [1:0] emit_kind;
        id_sel_t    emit_sel;
        logic       emit_last;
        logic       pop;
    } sadq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;
        logic       id_ok;
        logic       queued;
        logic       expired;
        logic       walk_end;
        logic       walk_zero;
        logic       gt_w;
        logic       le_now;
        logic       full;
        logic       out_free;
    } sadq_status_t;

endpackage

FILE: hdl/sadq_if.sv
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue channel interfaces
//
// Valid/ready channels for the operation requests and for the results.
// ----------------------------------------------------------------------------
interface sadq_cmd_if;

    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [3:0]  alarm_id;
    logic [63:0] sleep_ticks;
    logic [63:0] now;

    modport source (output valid, output func, output alarm_id, output sleep_ticks,
                    output now, input ready);
    modport sink (input valid, input func, input alarm_id, input sleep_ticks,
                  input now, output ready);

endinterface

interface sadq_res_if;

    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  woken_id;
    logic [63:0] compare_value;
    logic        last;

    modport source (output valid, output kind, output woken_id, output compare_value,
                    output last, input ready);
    modport sink (input valid, input kind, input woken_id, input compare_value,
                  input last, output ready);

endinterface

FILE: hdl/sorted_alarm_deadline_queue.sv
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue
//
// Keeps a 64-bit wake time per alarm and a queue of pending alarms sorted by
// wake time, and drives the timer compare value. Items are handled one at a
// time; a new item is taken while the previous result still waits in the
// result register. Sleep and interrupt handling walk through the queue,
// reading one wake time at a time from the single read port of the
// wake-time memory; an interrupt also waits whenever the result side
// stalls. The tick period register lies at byte address 0.
// ----------------------------------------------------------------------------
module sorted_alarm_deadline_queue
    import sadq_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sadq_cmd_if.sink              cmd,
    sadq_res_if.source            res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [31:0]  period_value;
    sadq_cmd_t    dp_cmd;
    sadq_status_t dp_status;

    // Configuration registers.
    sadq_apb_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .period_value (period_value)
    );

    // Sequencer.
    sadq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    // Queue, memory and result datapath.
    sadq_dp #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (cmd.func),
        .alarm_id      (cmd.alarm_id),
        .sleep_ticks   (cmd.sleep_ticks),
        .now           (cmd.now),
        .period_value  (period_value),
        .cmd           (dp_cmd),
        .status        (dp_status),
        .res_valid     (res.valid),
        .res_ready     (res.ready),
        .kind          (res.kind),
        .woken_id      (res.woken_id),
        .compare_value (res.compare_value),
        .last          (res.last)
    );

endmodule

FILE: hdl/sadq_apb_regs.sv
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue configuration registers
//
// APB-style register port holding the tick period. Writes complete in the
// access cycle; pready is tied high.
// ----------------------------------------------------------------------------
module sadq_apb_regs
    import sadq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [31:0]           period_value
);

    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [31:0]          period_reg;

    // Registers are word aligned; the low two address bits are ignored.
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Tick period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= TICK_PERIOD_RESET;
        end
        else if (wr_en && (reg_idx == REG_TICK_PERIOD))
        begin
            period_reg <= pwdata;
        end
    end

    // Read back; unmapped addresses read as zero.
    always_comb
    begin
        case (reg_idx)
            REG_TICK_PERIOD: prdata = period_reg;
            default:         prdata = '0;
        endcase
    end

    assign period_value = period_reg;

endmodule

FILE: hdl/sadq_dp.sv
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue datapath
//
// Holds the wake-time memory, the sorted pending queue, the periodic tick,
// the compare value and the result register. Acts on controller commands.
// ----------------------------------------------------------------------------
module sadq_dp
    import sadq_pkg::*;
#(
    parameter int NUM_ALARMS = NUM_ALARMS_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [1:0]   func,
    input  logic [3:0]   alarm_id,
    input  logic [63:0]  sleep_ticks,
    input  logic [63:0]  now,
    input  logic [31:0]  period_value,
    input  sadq_cmd_t    cmd,
    output sadq_status_t status,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [1:0]   kind,
    output logic [3:0]   woken_id,
    output logic [63:0]  compare_value,
    output logic         last
);

    localparam int IDX_W = $clog2(NUM_ALARMS);
    localparam int CNT_W = $clog2(NUM_ALARMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NUM_ALARMS);

    // Latched input item.
    logic [1:0]  func_reg;
    logic [3:0]  item_id_reg;
    logic [63:0] ticks_reg;
    logic [63:0] now_reg;

    // Wake-time memory with per-entry valid bits (unwritten entries read zero).
    logic [63:0]           wake_mem [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] wake_vld_reg;
    logic [63:0]           rd_data_reg;
    logic                  rd_vld_reg;
    logic [IDX_W-1:0]      rd_addr;
    logic [63:0]           rd_word;
    logic                  wr_en;
    logic [63:0]           wr_data;

    // Pending queue, sorted by wake time.
    logic [IDX_W-1:0]      order_reg  [NUM_ALARMS];
    logic [IDX_W-1:0]      order_next [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] queued_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      walk_reg;

    // Timing state.
    logic [63:0] w_reg;
    logic [63:0] ptick_reg;
    logic [63:0] compare_reg;

    // Result register.
    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [3:0]  out_id_reg;
    logic [63:0] out_cmp_reg;
    logic        out_last_reg;

    logic             id_ok;
    logic [IDX_W-1:0] id_idx;
    logic [IDX_W-1:0] walk_idx;
    logic [IDX_W-1:0] head_id;
    logic             head_valid;
    logic [64:0]      sleep_sum;
    logic [64:0]      tick_sum;
    logic [3:0]       emit_id;
    logic             out_free;

    // Address decode and arithmetic.
    assign id_ok      = {28'd0, item_id_reg} < 32'(NUM_ALARMS);
    assign id_idx     = IDX_W'(item_id_reg);
    assign walk_idx   = walk_reg[IDX_W-1:0];
    assign head_id    = order_reg[0];
    assign head_valid = (walk_reg != count_reg);
    assign rd_addr    = cmd.rd_walk ? order_reg[walk_idx] : id_idx;
    assign rd_word    = rd_vld_reg ? rd_data_reg : 64'd0;
    assign sleep_sum  = {1'b0, rd_word} + {1'b0, ticks_reg};
    assign tick_sum   = {1'b0, ptick_reg} + {33'd0, period_value};
    assign wr_en      = cmd.wr_now || cmd.wr_sleep;
    assign wr_data    = cmd.wr_now ? now_reg : w_reg;
    assign out_free   = !out_valid_reg || res_ready;

    // Capture the input item on a transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg    <= func;
            item_id_reg <= alarm_id;
            ticks_reg   <= sleep_ticks;
            now_reg     <= now;
        end
    end

    // Wake-time memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wake_mem[id_idx] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= wake_mem[rd_addr];
        end
    end

    // Valid bits of the wake-time memory and of the read data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wake_vld_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                wake_vld_reg[id_idx] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_vld_reg <= wake_vld_reg[rd_addr];
            end
        end
    end

    // Saturating sleep sum.
    always_ff @(posedge clk)
    begin
        if (cmd.add_sleep)
        begin
            w_reg <= sleep_sum[64] ? {64{1'b1}} : sleep_sum[63:0];
        end
    end

    // Queue order: insert at the walk position, or pop the head.
    always_comb
    begin
        order_next = order_reg;
        if (cmd.insert)
        begin
            for (int i = 1; i < NUM_ALARMS; i++)
            begin
                if (CNT_W'(i) > walk_reg)
                begin
                    order_next[i] = order_reg[i-1];
                end
            end
            order_next[walk_idx] = id_idx;
        end
        else if (cmd.pop)
        begin
            for (int i = 0; i < NUM_ALARMS - 1; i++)
            begin
                order_next[i] = order_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg <= order_next;
    end

    // Queue bookkeeping, periodic tick and compare value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg  <= '0;
            count_reg   <= '0;
            walk_reg    <= '0;
            ptick_reg   <= {32'd0, TICK_PERIOD_RESET};
            compare_reg <= {32'd0, TICK_PERIOD_RESET};
        end
        else
        begin
            if (cmd.insert)
            begin
                queued_reg[id_idx] <= 1'b1;
                count_reg          <= count_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                queued_reg[head_id] <= 1'b0;
                count_reg           <= count_reg - 1'b1;
            end

            if (cmd.walk_clr)
            begin
                walk_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
            else if (cmd.pop)
            begin
                walk_reg <= walk_reg - 1'b1;
            end

            // The periodic tick advances once when it lies in the past.
            if (cmd.tick_adv && (ptick_reg < now_reg))
            begin
                ptick_reg <= tick_sum[64] ? {64{1'b1}} : tick_sum[63:0];
            end

            // A new queue head ahead of the periodic tick pulls the compare in.
            if (cmd.insert && (walk_reg == '0) && (w_reg < ptick_reg))
            begin
                compare_reg <= w_reg;
            end
            else if (cmd.cmp_int)
            begin
                compare_reg <= (head_valid && (rd_word < ptick_reg)) ? rd_word : ptick_reg;
            end
        end
    end

    // Alarm id carried by the result.
    always_comb
    begin
        case (cmd.emit_sel)
            ID_ITEM: emit_id = item_id_reg;
            ID_HEAD: emit_id = 4'(head_id);
            default: emit_id = 4'd0;
        endcase
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.emit_kind;
            out_id_reg   <= emit_id;
            out_cmp_reg  <= compare_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res_valid     = out_valid_reg;
    assign kind          = out_kind_reg;
    assign woken_id      = out_id_reg;
    assign compare_value = out_cmp_reg;
    assign last          = out_last_reg;

    // Status back to the controller.
    assign status.func      = func_reg;
    assign status.id_ok     = id_ok;
    assign status.queued    = queued_reg[id_idx];
    assign status.expired   = (w_reg < now_reg);
    assign status.walk_end  = (walk_reg == count_reg);
    assign status.walk_zero = (walk_reg == '0);
    assign status.gt_w      = (w_reg > rd_word);
    assign status.le_now    = (rd_word <= now_reg);
    assign status.full      = (count_reg >= CNT_MAX);
    assign status.out_free  = out_free;

`ifndef SYNTH
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("pending count exceeds the number of alarms");

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(queued_reg) == int'(count_reg))
        else $error("queued flags disagree with the pending count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> ((walk_reg != '0) && (count_reg != '0)))
        else $error("pop from an empty queue or with no alarm left to wake");
`endif

endmodule

FILE: hdl/sadq_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue controller
//
// State machine that sequences rebase, sleep insert and timer interrupt
// handling through the datapath, one input item at a time.
// ----------------------------------------------------------------------------
module sadq_ctrl
    import sadq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sadq_status_t status,
    output sadq_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SLP_ADD,
        S_SLP_CHK,
        S_WALK_RD,
        S_WALK_CMP,
        S_INSERT,
        S_EMIT,
        S_INT_RD,
        S_INT_CMP,
        S_INT_TICK,
        S_INT_COMP,
        S_INT_EMIT
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] kind_reg;
    logic [1:0] kind_next;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end

            S_DECODE:
            begin
                kind_next  = KIND_ACK;
                state_next = S_EMIT;
                case (status.func)
                    FUNC_INTR:
                    begin
                        cmd.walk_clr = 1'b1;
                        state_next   = S_INT_RD;
                    end
                    FUNC_REBASE:
                    begin
                        cmd.wr_now = status.id_ok;
                    end
                    FUNC_SLEEP:
                    begin
                        if (status.id_ok)
                        begin
                            if (status.queued)
                            begin
                                kind_next = KIND_DUP;
                            end
                            else
                            begin
                                cmd.rd_en  = 1'b1;
                                state_next = S_SLP_ADD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
            end

            // Add the sleep ticks to the stored wake time.
            S_SLP_ADD:
            begin
                cmd.add_sleep = 1'b1;
                state_next    = S_SLP_CHK;
            end

            // Store the new wake time; a time already past is not queued.
            S_SLP_CHK:
            begin
                cmd.wr_sleep = 1'b1;
                if (status.expired)
                begin
                    kind_next  = KIND_EXPIRED;
                    state_next = S_EMIT;
                end
                else
                begin
                    cmd.walk_clr = 1'b1;
                    state_next   = S_WALK_RD;
                end
            end

            // Walk the queue for the first entry at or after the new time.
            S_WALK_RD:
            begin
                if (status.walk_end)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_walk = 1'b1;
                    state_next  = S_WALK_CMP;
                end
            end

            S_WALK_CMP:
            begin
                if (status.gt_w)
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = S_WALK_RD;
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end

            S_INSERT:
            begin
                cmd.insert = !status.full;
                state_next = S_EMIT;
            end

            // Single result of a rebase, a sleep or an unused operation code.
            S_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = kind_reg;
                    cmd.emit_sel  = ID_ITEM;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            // Count the due alarms from the queue head.
            S_INT_RD:
            begin
                if (status.walk_end)
                begin
                    state_next = S_INT_TICK;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_walk = 1'b1;
                    state_next  = S_INT_CMP;
                end
            end

            S_INT_CMP:
            begin
                if (status.le_now)
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = S_INT_RD;
                end
                else
                begin
                    state_next = S_INT_TICK;
                end
            end

            S_INT_TICK:
            begin
                cmd.tick_adv = 1'b1;
                state_next   = S_INT_COMP;
            end

            S_INT_COMP:
            begin
                cmd.cmp_int = 1'b1;
                state_next  = S_INT_EMIT;
            end

            // Pop and report each woken alarm, then the closing result.
            S_INT_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.walk_zero)
                    begin
                        cmd.emit_kind = KIND_ACK;
                        cmd.emit_sel  = ID_ZERO;
                        cmd.emit_last = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_kind = KIND_WOKEN;
                        cmd.emit_sel  = ID_HEAD;
                        cmd.emit_last = 1'b0;
                        cmd.pop       = 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered result kind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_ACK;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

`ifndef SYNTH
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result issued while the result register is occupied");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |-> !status.full)
        else $error("insert into a full queue");
`endif

endmodule

FILE: verif/deadline_result_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deadline queue result checker
//
// Watches the request, result and register ports of the sorted alarm
// deadline queue. It keeps its own copy of the alarm state, works out the
// results each accepted request should produce, and compares every result
// transfer field by field with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module deadline_result_check
    import sadq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sadq_cmd_if                   cmd,
    sadq_res_if                   res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    error_count,
    output int                    open_results,
    output int                    results_checked
);

    localparam int SLOTS = NUM_ALARMS_DEFAULT;

    // One expected result transfer.
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  alarm;
        logic [63:0] compare;
        logic        last;
    } alarm_result_t;

    alarm_result_t due_results[$];

    // Predicted block state.
    logic [31:0] period_reg;
    logic [63:0] alarm_wake [SLOTS];
    logic [3:0]  pend_list [SLOTS];
    int          pend_len;
    logic        alarm_queued [SLOTS];
    logic [63:0] tick_due;
    logic [63:0] cmp_value;

    function automatic logic [63:0] add_saturating(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[64] ? '1 : sum[63:0];
    endfunction

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    // Queue one expected result carrying the current compare value.
    task automatic post_result(input logic [1:0] kind, input logic [3:0] alarm,
                               input logic last);
        alarm_result_t r;
        r.kind    = kind;
        r.alarm   = alarm;
        r.compare = cmp_value;
        r.last    = last;
        due_results.push_back(r);
    endtask

    // Sleep: duplicate test, saturating add, expiry test, then sorted insert ahead of equal keys.
    task automatic predict_sleep(input logic [3:0] id, input logic [63:0] ticks,
                                 input logic [63:0] t_now);
        logic [63:0] w;
        int          pos;
        if (alarm_queued[id])
        begin
            post_result(KIND_DUP, id, 1'b1);
            return;
        end
        w = add_saturating(alarm_wake[id], ticks);
        alarm_wake[id] = w;
        if (w < t_now)
        begin
            post_result(KIND_EXPIRED, id, 1'b1);
            return;
        end
        if (pend_len >= SLOTS)
        begin
            post_result(KIND_ACK, id, 1'b1);
            return;
        end
        pos = 0;
        while (pos < pend_len && w > alarm_wake[pend_list[pos]])
            pos++;
        for (int i = pend_len; i > pos; i--)
            pend_list[i] = pend_list[i-1];
        pend_list[pos] = id;
        pend_len++;
        alarm_queued[id] = 1'b1;
        if (pos == 0 && w < tick_due)
            cmp_value = w;
        post_result(KIND_ACK, id, 1'b1);
    endtask

    // Interrupt: pop every due alarm from the head, step a past periodic tick once,
    // then pick the earlier of the head and the periodic tick.
    task automatic predict_interrupt(input logic [63:0] t_now);
        logic [3:0] woke[$];
        while (pend_len > 0 && alarm_wake[pend_list[0]] <= t_now)
        begin
            woke.push_back(pend_list[0]);
            alarm_queued[pend_list[0]] = 1'b0;
            for (int i = 0; i < pend_len - 1; i++)
                pend_list[i] = pend_list[i+1];
            pend_len--;
        end
        if (tick_due < t_now)
            tick_due = add_saturating(tick_due, {32'd0, period_reg});
        if (pend_len > 0 && alarm_wake[pend_list[0]] < tick_due)
            cmp_value = alarm_wake[pend_list[0]];
        else
            cmp_value = tick_due;
        foreach (woke[i])
            post_result(KIND_WOKEN, woke[i], 1'b0);
        post_result(KIND_ACK, 4'd0, 1'b1);
    endtask

    task automatic predict_item(input logic [1:0] f, input logic [3:0] id,
                                input logic [63:0] ticks, input logic [63:0] t_now);
        case (f)
            FUNC_INTR:   predict_interrupt(t_now);
            FUNC_SLEEP:  predict_sleep(id, ticks, t_now);
            FUNC_REBASE:
            begin
                alarm_wake[id] = t_now;
                post_result(KIND_ACK, id, 1'b1);
            end
            default:     post_result(KIND_ACK, id, 1'b1);
        endcase
    endtask

    // Compare one result transfer with the oldest expectation.
    task automatic check_result();
        alarm_result_t want;
        results_checked++;
        if (due_results.size() == 0)
        begin
            flag_mismatch($sformatf("unexpected result kind %0d id %0d", res.kind,
                                    res.woken_id));
            return;
        end
        want = due_results.pop_front();
        if (res.kind !== want.kind)
            flag_mismatch($sformatf("kind got %0d want %0d", res.kind, want.kind));
        if (res.woken_id !== want.alarm)
            flag_mismatch($sformatf("woken_id got %0d want %0d", res.woken_id, want.alarm));
        if (res.compare_value !== want.compare)
            flag_mismatch($sformatf("compare_value got %h want %h", res.compare_value,
                                    want.compare));
        if (res.last !== want.last)
            flag_mismatch($sformatf("last got %0b want %0b", res.last, want.last));
    endtask

    // Results are checked before new requests are predicted so that a result
    // never matches an expectation from the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg = TICK_PERIOD_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                alarm_wake[i]   = '0;
                pend_list[i]    = '0;
                alarm_queued[i] = 1'b0;
            end
            pend_len  = 0;
            tick_due  = {32'd0, TICK_PERIOD_RESET};
            cmp_value = {32'd0, TICK_PERIOD_RESET};
            due_results.delete();
            error_count     = 0;
            results_checked = 0;
            open_results <= 0;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (psel && penable && pwrite && pready &&
                paddr[APB_ADDR_W-1:2] == REG_TICK_PERIOD)
                period_reg = pwdata;
            if (cmd.valid && cmd.ready)
                predict_item(cmd.func, cmd.alarm_id, cmd.sleep_ticks, cmd.now);
            open_results <= due_results.size();
        end
    end

endmodule

FILE: verif/tb_sorted_alarm_deadline_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted alarm deadline queue testbench
//
// Drives rebase, sleep and interrupt requests through the request channel,
// with a directed opening followed by mostly well-formed random sequences
// and some noise, under several tick periods and idle patterns. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_sorted_alarm_deadline_queue;

    import sadq_pkg::*;

    localparam int TIMEOUT_CYCLES = 500000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 8;

    // Reserved operation code that the block acknowledges and ignores.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          error_count;
    int          open_results;
    int          results_checked;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_reqs_issued = 0;
    int          hold_reqs_served = 0;
    int          hold_left = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    logic [63:0] sim_now;

    sadq_cmd_if cmd_ch ();
    sadq_res_if res_ch ();

    sorted_alarm_deadline_queue DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    deadline_result_check result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd_ch),
        .res             (res_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .error_count     (error_count),
        .open_results    (open_results),
        .results_checked (results_checked)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_reqs_served != hold_reqs_issued)
        begin
            res_ch.ready     <= 1'b0;
            hold_left        <= HOLD_CYCLES;
            hold_reqs_served <= hold_reqs_served + 1;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, open_results);
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one request, idling first at the current rate, and wait for the transfer.
    task automatic send_op(input logic [1:0] f, input logic [3:0] id,
                           input logic [63:0] ticks, input logic [63:0] t_now);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.func        <= f;
        cmd_ch.alarm_id    <= id;
        cmd_ch.sleep_ticks <= ticks;
        cmd_ch.now         <= t_now;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result has been checked.
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_period(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TICK_PERIOD, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Arm every alarm, ask once more for a duplicate, then wake most of them.
    task automatic fill_queue();
        for (int i = 0; i < NUM_ALARMS_DEFAULT; i++)
        begin
            send_op(FUNC_REBASE, 4'(i), '0, sim_now);
            send_op(FUNC_SLEEP, 4'(i), 64'($urandom_range(0, 3000)), sim_now);
        end
        send_op(FUNC_SLEEP, 4'($urandom_range(15)), 64'd1, sim_now);
        sim_now = sim_now + $urandom_range(1500, 3500);
        send_op(FUNC_INTR, 4'($urandom_range(15)), '0, sim_now);
    endtask

    // One random request: mostly a coherent timeline, sometimes raw noise.
    task automatic send_random_op();
        int          pick;
        logic [3:0]  id;
        logic [63:0] ticks;
        logic [63:0] t_now;
        pick  = $urandom_range(99);
        id    = 4'($urandom_range(15));
        ticks = {$urandom, $urandom} >> $urandom_range(63);
        t_now = {$urandom, $urandom} >> $urandom_range(63);
        if (pick < 25)
            send_op(FUNC_REBASE, id, ticks, sim_now);
        else if (pick < 60)
            send_op(FUNC_SLEEP, id, 64'($urandom_range(0, 20000)), sim_now);
        else if (pick < 80)
        begin
            sim_now = sim_now + $urandom_range(0, 6000);
            send_op(FUNC_INTR, id, ticks, sim_now);
        end
        else
            send_op(2'($urandom_range(3)), id, ticks, t_now);
    endtask

    task automatic random_phase(input int count);
        int start;
        start = items_sent;
        while (items_sent - start < count)
        begin
            if ($urandom_range(39) == 0)
                fill_queue();
            else
                send_random_op();
        end
    endtask

    // Main stimulus sequence.
    initial
    begin
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.func        <= FUNC_REBASE;
        cmd_ch.alarm_id    <= '0;
        cmd_ch.sleep_ticks <= '0;
        cmd_ch.now         <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        sim_now             = 64'd10000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening at the reset tick period.
        send_op(FUNC_INTR, 4'd0, '0, '0);
        send_op(FUNC_REBASE, 4'd0, '0, 64'd1000);
        send_op(FUNC_SLEEP, 4'd0, 64'd500, 64'd1000);
        // A second sleep on a queued alarm is rejected.
        send_op(FUNC_SLEEP, 4'd0, 64'd7, 64'd1000);
        // Wake time saturates at all-ones and is still queued.
        send_op(FUNC_REBASE, 4'd15, '0, '1);
        send_op(FUNC_SLEEP, 4'd15, '1, '1);
        // Equal wake times: the newer alarm goes ahead.
        send_op(FUNC_REBASE, 4'd3, '0, 64'd2000);
        send_op(FUNC_SLEEP, 4'd3, '0, 64'd2000);
        send_op(FUNC_REBASE, 4'd4, '0, 64'd2000);
        send_op(FUNC_SLEEP, 4'd4, '0, 64'd2000);
        // Sleep that lands in the past reports expired.
        send_op(FUNC_SLEEP, 4'd5, 64'd10, 64'd5000);
        send_op(FUNC_UNUSED, 4'd9, '1, '1);
        // Rebase of a queued alarm leaves the queue order alone.
        send_op(FUNC_REBASE, 4'd3, '0, 64'd10);
        send_op(FUNC_INTR, 4'd0, '0, 64'd1600);
        send_op(FUNC_INTR, 4'd7, '1, 64'd300000);
        send_op(FUNC_SLEEP, 4'd7, 64'h8000_0000_0000_0000, '0);
        send_op(FUNC_REBASE, 4'd10, '0, 64'h5555_5555_5555_5555);
        send_op(FUNC_SLEEP, 4'd10, 64'hAAAA_AAAA_AAAA_AAAA, '0);
        send_op(FUNC_INTR, 4'd0, '0, '1);
        send_op(FUNC_INTR, 4'd0, '0, '0);
        wait_idle();

        // Receiver idles more than the sender.
        write_period(32'd5000);
        send_idle_pct  = 35;
        recv_idle_pct <= 60;
        random_phase(110);
        wait_idle();

        // Sender idles more than the receiver, with the smallest nonzero tick period.
        write_period(32'd1);
        send_idle_pct  = 60;
        recv_idle_pct <= 35;
        random_phase(110);
        wait_idle();

        // No idling; a long receiver hold-off lets the block back up.
        write_period(32'hFFFF_FFFF);
        send_idle_pct     = 0;
        recv_idle_pct    <= 0;
        hold_reqs_issued <= hold_reqs_issued + 1;
        random_phase(50);
        wait_idle();

        // A zero tick period stops the periodic tick.
        write_period(32'd0);
        random_phase(50);
        wait_idle();

        $display("Covered %0d requests and %0d result transfers", items_sent,
                 results_checked);
        $display("Tick periods: reset, 5000, 1, all-ones and zero, under mixed stalls");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
